>>> rtl/aalf_pkg.sv
// ----------------------------------------------------------------------------
// aalf_pkg
// Shared constants for the address accept list filter: default slot
// contents, operation and status codes, advert kinds and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package aalf_pkg;

  // Table geometry default.
  localparam int SLOTS_DEFAULT = 8;

  // Address width of one device address.
  localparam int ADDR_W = 48;

  // Addresses loaded into slots 0 and 1 at reset.
  localparam logic [ADDR_W-1:0] DEFAULT_ADDR_A = 48'hD229_B2D0_66FC;
  localparam logic [ADDR_W-1:0] DEFAULT_ADDR_B = 48'h7CDF_A1FB_727D;

  // Reset value of the signal strength floor in dBm.
  localparam logic signed [7:0] FLOOR_RESET = -8'sd100;

  // Operation codes. Any code with bit 1 set runs a check.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_CHECKED   = 3'd5;

  // Connectable advert kinds.
  localparam logic [2:0] KIND_ADV_IND    = 3'd0;
  localparam logic [2:0] KIND_DIRECT_IND = 3'd1;
  localparam logic [2:0] KIND_EXT_ADV    = 3'd5;

  // Register byte address of rssi_floor.
  localparam logic [1:0] REG_RSSI_FLOOR = 2'd0;

endpackage

`default_nettype wire

>>> rtl/aalf_store.sv
// ----------------------------------------------------------------------------
// aalf_store
// Slot address memory with one write port and one registered read port.
// Slots 0 and 1 read as the default addresses until they are first written.
// ----------------------------------------------------------------------------
`default_nettype none

module aalf_store #(
  parameter int SLOTS = aalf_pkg::SLOTS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [$clog2(SLOTS)-1:0]    rd_idx,
  output logic      [aalf_pkg::ADDR_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(SLOTS)-1:0]    wr_idx,
  input  wire logic [aalf_pkg::ADDR_W-1:0] wr_data
);

  localparam int IW = $clog2(SLOTS);

  logic [aalf_pkg::ADDR_W-1:0] mem [SLOTS];
  logic [aalf_pkg::ADDR_W-1:0] rd_mem;
  logic [1:0]                  dflt;
  logic [1:0]                  rd_sel;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_mem <= mem[rd_idx];
  end

  // Default overlay marks: set at reset, cleared by the first write to the slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt   <= 2'b11;
      rd_sel <= 2'b00;
    end else begin
      if (wr_en && wr_idx == IW'(0)) begin
        dflt[0] <= 1'b0;
      end
      if (wr_en && wr_idx == IW'(1)) begin
        dflt[1] <= 1'b0;
      end
      rd_sel[0] <= dflt[0] && rd_idx == IW'(0);
      rd_sel[1] <= dflt[1] && rd_idx == IW'(1);
    end
  end

  // Select the default address for a slot that still holds it.
  always_comb begin
    if (rd_sel[0]) begin
      rd_data = aalf_pkg::DEFAULT_ADDR_A;
    end else if (rd_sel[1]) begin
      rd_data = aalf_pkg::DEFAULT_ADDR_B;
    end else begin
      rd_data = rd_mem;
    end
  end

endmodule

`default_nettype wire

>>> rtl/address_accept_list_filter.sv
// ----------------------------------------------------------------------------
// address_accept_list_filter
// Accept list of device addresses with add, remove and advert check.
// ----------------------------------------------------------------------------
// One 48-bit comparator walks the slot memory one entry per cycle, then the
// finishing state applies the update, and busy drops in the cycle that carries
// the done strobe; a new item is taken only once busy has dropped.
// Reset: slots 0 and 1 hold the default addresses and are valid, the count is
// 2 and rssi_floor is -100. The receiver cannot stall the result strobe.
`default_nettype none

module address_accept_list_filter #(
  parameter int SLOTS = aalf_pkg::SLOTS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Command channel.
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic [47:0]        device_address,
  input  wire logic [2:0]         advert_kind,
  input  wire logic signed [7:0]  signal_dbm,
  input  wire logic               link_pending,
  // Result channel.
  output logic                    done,
  output logic [2:0]              op_status,
  output logic                    address_listed,
  output logic                    grant_connect,
  output logic [3:0]              listed_count,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t                 state;
  logic [CW-1:0]          scan_cnt;
  logic [IW-1:0]          rd_idx;
  logic [IW-1:0]          cmp_idx;
  logic [47:0]            rd_data;

  // Latched item.
  logic [1:0]             func_q;
  logic [47:0]            addr_q;
  logic [2:0]             kind_q;
  logic signed [7:0]      sig_q;
  logic                   pending_q;

  // Scan results.
  logic                   hit_found;
  logic [IW-1:0]          hit_idx;
  logic                   free_found;
  logic [IW-1:0]          free_idx;

  logic [SLOTS-1:0]       slot_valid;
  logic [CW-1:0]          valid_total;
  logic [LW-1:0]          count_wide;
  logic signed [7:0]      rssi_floor;

  logic                   is_match;
  logic                   do_add;
  logic                   connectable;
  logic                   wr_en;

  // Configuration writes and reads.
  assign pready = 1'b1;
  assign prdata = (paddr == aalf_pkg::REG_RSSI_FLOOR) ? 32'(rssi_floor) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_floor <= aalf_pkg::FLOOR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == aalf_pkg::REG_RSSI_FLOOR) begin
      rssi_floor <= pwdata[7:0];
    end
  end

  // Slot memory walked by the scan counter.
  assign rd_idx  = scan_cnt[IW-1:0];
  assign cmp_idx = IW'(scan_cnt - CW'(1));
  assign is_match = slot_valid[cmp_idx] && rd_data == addr_q;

  aalf_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_idx (free_idx),
    .wr_data(addr_q)
  );

  // Update decisions for the finishing cycle.
  always_comb begin
    case (kind_q) inside
      aalf_pkg::KIND_ADV_IND, aalf_pkg::KIND_DIRECT_IND, aalf_pkg::KIND_EXT_ADV:
        connectable = 1'b1;
      default:
        connectable = 1'b0;
    endcase
  end

  assign do_add = state == FINISH && func_q == aalf_pkg::FUNC_ADD
                  && !hit_found && free_found;
  assign wr_en  = do_add;

  // Sequencer, table state and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      scan_cnt       <= '0;
      hit_found      <= 1'b0;
      free_found     <= 1'b0;
      slot_valid     <= SLOTS'(2'b11);
      valid_total    <= CW'(2);
      done           <= 1'b0;
    end else begin
      done <= (state == FINISH);
      unique case (state)
        IDLE: begin
          if (start) begin
            func_q     <= func;
            addr_q     <= device_address;
            kind_q     <= advert_kind;
            sig_q      <= signal_dbm;
            pending_q  <= link_pending;
            scan_cnt   <= '0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          // Read of slot scan_cnt is issued; slot scan_cnt-1 is compared.
          if (scan_cnt != '0) begin
            if (!hit_found && is_match) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
            end
            if (!free_found && !slot_valid[cmp_idx]) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
          if (scan_cnt == CW'(SLOTS)) begin
            state <= FINISH;
          end else begin
            scan_cnt <= scan_cnt + CW'(1);
          end
        end
        FINISH: begin
          address_listed <= hit_found;
          if (func_q == aalf_pkg::FUNC_ADD) begin
            grant_connect <= 1'b0;
            if (hit_found) begin
              op_status <= aalf_pkg::ST_PRESENT;
            end else if (free_found) begin
              op_status            <= aalf_pkg::ST_ADDED;
              slot_valid[free_idx] <= 1'b1;
              valid_total          <= valid_total + CW'(1);
            end else begin
              op_status <= aalf_pkg::ST_FULL;
            end
          end else if (func_q == aalf_pkg::FUNC_REMOVE) begin
            grant_connect <= 1'b0;
            if (hit_found) begin
              op_status           <= aalf_pkg::ST_REMOVED;
              slot_valid[hit_idx] <= 1'b0;
              if (valid_total != '0) begin
                valid_total <= valid_total - CW'(1);
              end
            end else begin
              op_status <= aalf_pkg::ST_NOT_FOUND;
            end
          end else begin
            op_status     <= aalf_pkg::ST_CHECKED;
            grant_connect <= connectable && !pending_q && sig_q >= rssi_floor
                             && hit_found;
          end
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy         = state != IDLE;
  assign count_wide   = LW'(valid_total);
  assign listed_count = count_wide[3:0];

  // The count always agrees with the valid marks.
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    valid_total == CW'($countones(slot_valid)))
    else $error("valid count disagrees with valid marks");

  // A result appears only after the finishing cycle.
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == FINISH))
    else $error("result strobe without a finishing cycle");

  // A grant needs a listed address.
  a_grant_listed: assert property (@(posedge clk) disable iff (rst)
    done && grant_connect |-> address_listed && op_status == aalf_pkg::ST_CHECKED)
    else $error("grant without a listed address");

  // Full is only reported when every slot is valid.
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    done && op_status == aalf_pkg::ST_FULL |-> &slot_valid)
    else $error("table full reported with a free slot");

endmodule

`default_nettype wire
